@@ rtl/psopu_pkg.sv @@
// Shared constants, operation codes and saturation helpers for the particle update block.
// Used by the top level and the multiplier under rtl; depends on nothing else.
`default_nettype none

package psopu_pkg;

    // Vector length of the particle and the widths that follow from it.
    localparam int DIMENSIONS = 8;
    localparam int ADDR_W     = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int CNT_W      = $clog2(DIMENSIONS + 1);

    // Field widths.
    localparam int OP_W      = 3;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 32;
    localparam int RAND_W    = 16;
    localparam int FIT_W     = 31;
    localparam int PROD_W    = 48;
    localparam int DOT_W     = 48;
    localparam int ACC_W     = 50;
    localparam int CFG_IDX_W = 3;

    // Stream bus widths.
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 64;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_EVAL    = 3'd1;
    localparam logic [OP_W-1:0] OP_VEL     = 3'd2;
    localparam logic [OP_W-1:0] OP_POS     = 3'd3;
    localparam logic [OP_W-1:0] OP_PERTURB = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INERTIA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWARM_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER      = 3'd4;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] y;
        if (x > 50'sh0_0000_7FFF_FFFF) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -50'sh0_0000_8000_0000) begin
            y = -32'sh8000_0000;
        end else begin
            y = x[DATA_W-1:0];
        end
        return y;
    endfunction

    // Saturate a 49-bit signed sum to the signed 48-bit accumulator range.
    function automatic logic signed [DOT_W-1:0] f_sat48(input logic signed [DOT_W:0] x);
        logic signed [DOT_W-1:0] y;
        if (x > 49'sh0_7FFF_FFFF_FFFF) begin
            y = 48'sh7FFF_FFFF_FFFF;
        end else if (x < -49'sh0_8000_0000_0000) begin
            y = -48'sh8000_0000_0000;
        end else begin
            y = x[DOT_W-1:0];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pso_particle_update_top.sv @@
// Top level of the particle update block: sequencer, state vectors and result register.
// Depends on psopu_pkg, psopu_ram and psopu_mul.
//
// Usage. The block holds one swarm particle. Each input transfer on the slave
// stream addresses one vector element; tuser carries the operation (load,
// evaluate, velocity update, position update, perturb) and tlast marks the last
// element of an evaluate pass. Every accepted transfer yields exactly one result
// transfer on the master stream: the new position or velocity element, and on
// the last evaluate element the fitness with its valid and improved flags.
// Configuration registers (inertia, two gains, two position limits) must be written
// through the plain write port only while no item is in flight; the block itself
// does not enforce this.
//
// Sequencing. One item is worked on at a time and o_s_tready is low meanwhile.
// Load, position update and perturb pass S_OP and S_DONE; evaluate adds S_ACC,
// the last evaluate element S_FIT, and S_COPY when the personal best improves
// and the position vector is copied through the RAM ports. Velocity update runs
// S_VEL, where the single shared multiplier forms five dependent products in turn.
//
// Reset clears the sequencer and output valid, loads the register reset values,
// sets the best fitness to its maximum and clears the dot product. The vector
// RAMs are not cleared. When the receiver stalls, the finished result waits in
// the output register and the next result waits in the sequencer until it drains.
`default_nettype none

module pso_particle_update_top
    import psopu_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Slave stream.
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    // tdata from bit 0: elem_index[3], value_a[32], value_b[32], target[32],
    // rand_own[16], rand_swarm[16], zero fill[5].
    input  wire logic [S_TDATA_W-1:0]    i_s_tdata,
    // tuser: op[3].
    input  wire logic [S_TUSER_W-1:0]    i_s_tuser,
    input  wire logic                    i_s_tlast,
    // Master stream.
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    // tdata from bit 0: elem_value[32], fitness[31], improved[1].
    output logic [M_TDATA_W-1:0]         o_m_tdata,
    // tuser: fitness_valid[1].
    output logic                         o_m_tuser,
    // Configuration write port.
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [DATA_W-1:0]       i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OP   = 7'b0000010,
        S_VEL  = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_FIT  = 7'b0010000,
        S_COPY = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    localparam logic [2:0] VEL_LAST_STEP = 3'd4;

    t_state r_state, n_state;

    // Latched input item.
    logic [OP_W-1:0]           r_op;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_ok;
    logic                      r_last;
    logic signed [DATA_W-1:0]  r_va, r_vb, r_tgt;
    logic [RAND_W-1:0]         r_r1, r_r2;

    // Configuration registers.
    logic signed [DATA_W-1:0]  r_cfg_w, r_cfg_c1, r_cfg_c2, r_cfg_lo, r_cfg_hi;

    // Particle scalars and work registers.
    logic [DATA_W-1:0]         r_best_fit;
    logic signed [DOT_W-1:0]   r_dot;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [DATA_W-1:0]  r_g, r_d1, r_d2;
    logic [2:0]                r_step;
    logic [CNT_W-1:0]          r_cnt;

    // Staged result and output register.
    logic signed [DATA_W-1:0]  r_res_value;
    logic [FIT_W-1:0]          r_res_fit;
    logic                      r_res_fv, r_res_impr;
    logic [DATA_W-1:0]         r_m_value;
    logic [FIT_W-1:0]          r_m_fit;
    logic                      r_m_fv, r_m_impr, r_m_valid;

    // Input fields.
    logic [IDX_W-1:0]          w_in_idx;
    logic signed [DATA_W-1:0]  w_in_va, w_in_vb, w_in_tgt;
    logic [RAND_W-1:0]         w_in_r1, w_in_r2;
    logic                      w_in_acc, w_out_free;

    // RAM ports.
    logic [ADDR_W-1:0]         w_addr, w_in_addr, w_pos_rd_addr, w_best_wr_addr;
    logic                      w_pos_we, w_spd_we, w_best_we;
    logic [DATA_W-1:0]         w_pos_wd, w_spd_wd, w_best_wd;
    logic [DATA_W-1:0]         w_pos_q, w_spd_q, w_best_q;
    logic signed [DATA_W-1:0]  w_pos_rd, w_spd_rd, w_best_rd;

    // Datapath.
    logic signed [DATA_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [DATA_W:0]    w_pos_sum;
    logic signed [DATA_W-1:0]  w_pos_new;
    logic                      w_clamped;
    logic signed [DATA_W-1:0]  w_perturb, w_vel_new, w_d1, w_d2;
    logic signed [ACC_W-1:0]   w_vel_sum;
    logic signed [DOT_W-1:0]   w_dot_new;
    logic signed [DOT_W:0]     w_diff, w_abs;
    logic [FIT_W-1:0]          w_fit;
    logic                      w_impr;

    assign w_in_idx = i_s_tdata[2:0];
    assign w_in_va  = i_s_tdata[34:3];
    assign w_in_vb  = i_s_tdata[66:35];
    assign w_in_tgt = i_s_tdata[98:67];
    assign w_in_r1  = i_s_tdata[114:99];
    assign w_in_r2  = i_s_tdata[130:115];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;

    assign w_addr    = ADDR_W'(r_idx);
    assign w_in_addr = ADDR_W'(w_in_idx);

    // Read data of the three vectors.
    assign w_pos_rd  = w_pos_q;
    assign w_spd_rd  = w_spd_q;
    assign w_best_rd = w_best_q;

    // Position update: exact sum, then clamp, upper bound tested first.
    assign w_pos_sum = (DATA_W+1)'(w_pos_rd) + (DATA_W+1)'(w_spd_rd);
    always_comb begin
        w_clamped = 1'b1;
        if (w_pos_sum > (DATA_W+1)'(r_cfg_hi)) begin
            w_pos_new = r_cfg_hi;
        end else if (w_pos_sum < (DATA_W+1)'(r_cfg_lo)) begin
            w_pos_new = r_cfg_lo;
        end else begin
            w_pos_new = w_pos_sum[DATA_W-1:0];
            w_clamped = 1'b0;
        end
    end

    assign w_perturb = f_sat32(ACC_W'(w_spd_rd) + ACC_W'(r_va));
    assign w_d1      = f_sat32(ACC_W'(w_best_rd) - ACC_W'(w_pos_rd));
    assign w_d2      = f_sat32(ACC_W'(r_va) - ACC_W'(w_pos_rd));
    assign w_vel_sum = r_acc + ACC_W'(w_prod);
    assign w_vel_new = f_sat32(w_vel_sum);
    assign w_dot_new = f_sat48((DOT_W+1)'(r_dot) + (DOT_W+1)'(w_prod));

    // Fitness: |dot - target| saturated to 31 bits, strictly lower wins.
    assign w_diff = (DOT_W+1)'(r_dot) - (DOT_W+1)'(r_tgt);
    assign w_abs  = w_diff[DOT_W] ? -w_diff : w_diff;
    assign w_fit  = (w_abs > (DOT_W+1)'(32'sh7FFF_FFFF)) ? {FIT_W{1'b1}} : w_abs[FIT_W-1:0];
    assign w_impr = ({1'b0, w_fit} < r_best_fit);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_OP: begin
                if (r_op == OP_EVAL) begin
                    w_mul_a = r_va;
                    w_mul_b = r_ok ? w_pos_rd : '0;
                end else if (r_op == OP_VEL) begin
                    w_mul_a = r_cfg_w;
                    w_mul_b = w_spd_rd;
                end
            end
            S_VEL: begin
                case (r_step)
                    3'd0: begin
                        w_mul_a = r_cfg_c1;
                        w_mul_b = DATA_W'(r_r1);
                    end
                    3'd1: begin
                        w_mul_a = r_cfg_c2;
                        w_mul_b = DATA_W'(r_r2);
                    end
                    3'd2: begin
                        w_mul_a = r_g;
                        w_mul_b = r_d1;
                    end
                    3'd3: begin
                        w_mul_a = r_g;
                        w_mul_b = r_d2;
                    end
                    default: begin
                        w_mul_a = '0;
                        w_mul_b = '0;
                    end
                endcase
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    psopu_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // RAM write controls.
    always_comb begin
        w_pos_we       = 1'b0;
        w_pos_wd       = r_va;
        w_spd_we       = 1'b0;
        w_spd_wd       = r_vb;
        w_best_we      = 1'b0;
        w_best_wd      = r_va;
        w_best_wr_addr = w_addr;
        case (r_state)
            S_OP: begin
                if (r_ok) begin
                    if (r_op == OP_LOAD) begin
                        w_pos_we  = 1'b1;
                        w_spd_we  = 1'b1;
                        w_best_we = 1'b1;
                    end else if (r_op == OP_POS) begin
                        w_pos_we = 1'b1;
                        w_pos_wd = w_pos_new;
                        w_spd_we = w_clamped;
                        w_spd_wd = '0;
                    end else if (r_op == OP_PERTURB) begin
                        w_spd_we = 1'b1;
                        w_spd_wd = w_perturb;
                    end
                end
            end
            S_VEL: begin
                if (r_step == VEL_LAST_STEP) begin
                    w_spd_we = 1'b1;
                    w_spd_wd = w_vel_new;
                end
            end
            S_COPY: begin
                // Read of element k lands in the next cycle, so write element k - 1.
                w_best_we      = (r_cnt != '0);
                w_best_wd      = w_pos_rd;
                w_best_wr_addr = ADDR_W'(r_cnt - CNT_W'(1));
            end
            default: begin
                w_pos_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (r_state == S_IDLE) begin
            w_pos_rd_addr = w_in_addr;
        end else if (r_state == S_COPY) begin
            w_pos_rd_addr = r_cnt[ADDR_W-1:0];
        end else begin
            w_pos_rd_addr = w_addr;
        end
    end

    psopu_ram #(.WIDTH(DATA_W), .DEPTH(DIMENSIONS)) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_pos_we),
        .i_wr_addr (w_addr),
        .i_wr_data (w_pos_wd),
        .i_rd_addr (w_pos_rd_addr),
        .o_rd_data (w_pos_q)
    );

    psopu_ram #(.WIDTH(DATA_W), .DEPTH(DIMENSIONS)) u_spd_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_spd_we),
        .i_wr_addr (w_addr),
        .i_wr_data (w_spd_wd),
        .i_rd_addr ((r_state == S_IDLE) ? w_in_addr : w_addr),
        .o_rd_data (w_spd_q)
    );

    psopu_ram #(.WIDTH(DATA_W), .DEPTH(DIMENSIONS)) u_best_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_best_we),
        .i_wr_addr (w_best_wr_addr),
        .i_wr_data (w_best_wd),
        .i_rd_addr ((r_state == S_IDLE) ? w_in_addr : w_addr),
        .o_rd_data (w_best_q)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_OP;
                end
            end
            S_OP: begin
                if (r_op == OP_EVAL) begin
                    n_state = S_ACC;
                end else if (r_op == OP_VEL && r_ok) begin
                    n_state = S_VEL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_VEL: begin
                if (r_step == VEL_LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_ACC: begin
                n_state = r_last ? S_FIT : S_DONE;
            end
            S_FIT: begin
                n_state = w_impr ? S_COPY : S_DONE;
            end
            S_COPY: begin
                if (r_cnt == CNT_W'(DIMENSIONS)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= '0;
            r_cfg_c1 <= '0;
            r_cfg_c2 <= '0;
            r_cfg_lo <= -32'sh8000_0000;
            r_cfg_hi <= 32'sh7FFF_FFFF;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_INERTIA:    r_cfg_w  <= i_cfg_data;
                CFG_OWN_GAIN:   r_cfg_c1 <= i_cfg_data;
                CFG_SWARM_GAIN: r_cfg_c2 <= i_cfg_data;
                CFG_LOWER:      r_cfg_lo <= i_cfg_data;
                CFG_UPPER:      r_cfg_hi <= i_cfg_data;
                default:        r_cfg_w  <= r_cfg_w;
            endcase
        end
    end

    // Particle scalars that carry reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_fit <= '1;
            r_dot      <= '0;
        end else begin
            if (r_state == S_OP && r_op == OP_LOAD) begin
                r_best_fit <= '1;
            end
            if (r_state == S_ACC) begin
                r_dot <= w_dot_new;
            end
            if (r_state == S_FIT) begin
                r_dot <= '0;
                if (w_impr) begin
                    r_best_fit <= DATA_W'(w_fit);
                end
            end
        end
    end

    // Item latch, work registers and staged result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_op        <= i_s_tuser;
                    r_idx       <= w_in_idx;
                    r_ok        <= (int'(w_in_idx) < DIMENSIONS);
                    r_last      <= i_s_tlast;
                    r_va        <= w_in_va;
                    r_vb        <= w_in_vb;
                    r_tgt       <= w_in_tgt;
                    r_r1        <= w_in_r1;
                    r_r2        <= w_in_r2;
                    r_res_value <= '0;
                    r_res_fit   <= '0;
                    r_res_fv    <= 1'b0;
                    r_res_impr  <= 1'b0;
                end
            end
            S_OP: begin
                r_step <= '0;
                r_d1   <= w_d1;
                r_d2   <= w_d2;
                if (r_ok) begin
                    if (r_op == OP_LOAD) begin
                        r_res_value <= r_va;
                    end else if (r_op == OP_POS) begin
                        r_res_value <= w_pos_new;
                    end else if (r_op == OP_PERTURB) begin
                        r_res_value <= w_perturb;
                    end
                end
            end
            S_VEL: begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd0: r_acc <= ACC_W'(w_prod);
                    3'd1: r_g   <= w_prod[DATA_W-1:0];
                    3'd2: r_g   <= w_prod[DATA_W-1:0];
                    3'd3: r_acc <= w_vel_sum;
                    default: r_res_value <= w_vel_new;
                endcase
            end
            S_FIT: begin
                r_res_fit  <= w_fit;
                r_res_fv   <= 1'b1;
                r_res_impr <= w_impr;
                r_cnt      <= '0;
            end
            S_COPY: begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // Output register: takes the staged result once the previous one has left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_m_value <= r_res_value;
            r_m_fit   <= r_res_fit;
            r_m_fv    <= r_res_fv;
            r_m_impr  <= r_res_impr;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_impr, r_m_fit, r_m_value};
    assign o_m_tuser  = r_m_fv;

    // An accepted item always starts work.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_OP))
        else $error("accepted item did not start execution");

    // The best fitness only falls, except when a load resets it.
    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !(r_state == S_OP && r_op == OP_LOAD)) |=> (r_best_fit <= $past(r_best_fit)))
        else $error("best fitness rose without a load");

    // The dot product restarts after each completed evaluation.
    a_dot_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIT) |=> (r_dot == '0))
        else $error("dot product not cleared after evaluation");

    // The copy sweep never runs past the vector.
    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_cnt <= CNT_W'(DIMENSIONS)))
        else $error("best-position copy ran past the vector");

    // A stalled result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_tready) |=> (r_m_valid && $stable(o_m_tdata)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/psopu_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the position, velocity and best-position vectors.
`default_nettype none

module psopu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_wr_en,
    input  wire logic [AW-1:0]          i_wr_addr,
    input  wire logic [WIDTH-1:0]       i_wr_data,
    input  wire logic [AW-1:0]          i_rd_addr,
    output logic      [WIDTH-1:0]       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/psopu_mul.sv @@
// Shared signed 32x32 multiplier with a registered Q32.16 result (floor rounding).
// Depends on psopu_pkg for the operand and product widths.
`default_nettype none

module psopu_mul
    import psopu_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic signed [DATA_W-1:0]    i_a,
    input  wire logic signed [DATA_W-1:0]    i_b,
    output logic signed      [PROD_W-1:0]    o_prod
);

    logic signed [2*DATA_W-1:0] w_full;
    logic signed [PROD_W-1:0]   r_prod;

    // Dropping the low 16 bits of a two's complement product rounds toward minus infinity.
    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[2*DATA_W-1:16];
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ tb/pso_particle_update_check.sv @@
`timescale 1ns / 1ps
// Watches both streams and the configuration port of the particle update block,
// predicts every result transfer and compares it field by field. Depends on psopu_pkg.
module pso_particle_update_check
    import psopu_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    input  wire logic                    i_s_tready,
    // tdata from bit 0: elem_index[3], value_a[32], value_b[32], target[32],
    // rand_own[16], rand_swarm[16], zero fill[5].
    input  wire logic [S_TDATA_W-1:0]    i_s_tdata,
    // tuser: op[3].
    input  wire logic [S_TUSER_W-1:0]    i_s_tuser,
    input  wire logic                    i_s_tlast,
    input  wire logic                    i_m_tvalid,
    input  wire logic                    i_m_tready,
    // tdata from bit 0: elem_value[32], fitness[31], improved[1].
    input  wire logic [M_TDATA_W-1:0]    i_m_tdata,
    // tuser: fitness_valid[1].
    input  wire logic                    i_m_tuser,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [DATA_W-1:0]       i_cfg_data,
    output int                           o_errors,
    output int                           o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] elem_value;
        logic [FIT_W-1:0]         fitness;
        logic                     fitness_valid;
        logic                     improved;
    } t_particle_result;

    localparam longint DOT_HI = 64'sd140737488355327;
    localparam longint DOT_LO = -DOT_HI - 1;
    localparam longint Q_HI   = 64'sd2147483647;
    localparam longint Q_LO   = -Q_HI - 1;

    // Own copy of the particle and of the register file.
    logic signed [DATA_W-1:0] pos_mem   [DIMENSIONS];
    logic signed [DATA_W-1:0] speed_mem [DIMENSIONS];
    logic signed [DATA_W-1:0] best_mem  [DIMENSIONS];
    logic signed [DATA_W-1:0] cfg_regs  [CFG_UPPER+1];
    logic [DATA_W-1:0]        best_fit;
    longint                   dot_acc;

    t_particle_result expected_results[$];

    function automatic longint clip32(input longint x);
        if (x > Q_HI) return Q_HI;
        if (x < Q_LO) return Q_LO;
        return x;
    endfunction

    // Exact product, then floor of the division by 2^16.
    function automatic longint mul_q16(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic t_particle_result predict_particle_step(
        input logic [OP_W-1:0]          op,
        input logic [IDX_W-1:0]         idx,
        input logic signed [DATA_W-1:0] va,
        input logic signed [DATA_W-1:0] vb,
        input logic signed [DATA_W-1:0] tgt,
        input logic [RAND_W-1:0]        r1,
        input logic [RAND_W-1:0]        r2,
        input logic                     last
    );
        t_particle_result res;
        longint acc, diff, g1, g2, d1, d2, vel_sum, next_pos;
        res = '0;
        case (op)
            OP_LOAD: begin
                pos_mem[idx]   = va;
                best_mem[idx]  = va;
                speed_mem[idx] = vb;
                res.elem_value = va;
                best_fit       = '1;
            end
            OP_EVAL: begin
                acc = dot_acc + mul_q16(longint'(va), longint'(pos_mem[idx]));
                if (acc > DOT_HI) acc = DOT_HI;
                else if (acc < DOT_LO) acc = DOT_LO;
                dot_acc = acc;
                if (last) begin
                    diff = dot_acc - longint'(tgt);
                    if (diff < 0) diff = -diff;
                    if (diff > Q_HI) diff = Q_HI;
                    res.fitness       = diff[FIT_W-1:0];
                    res.fitness_valid = 1'b1;
                    // Unsigned compare against the stored best; ties do not win.
                    if (diff < longint'(best_fit)) begin
                        best_fit = DATA_W'(diff);
                        for (int k = 0; k < DIMENSIONS; k++) best_mem[k] = pos_mem[k];
                        res.improved = 1'b1;
                    end
                    dot_acc = 0;
                end
            end
            OP_VEL: begin
                g1 = (longint'(cfg_regs[CFG_OWN_GAIN]) * longint'(r1)) >>> 16;
                g2 = (longint'(cfg_regs[CFG_SWARM_GAIN]) * longint'(r2)) >>> 16;
                d1 = clip32(longint'(best_mem[idx]) - longint'(pos_mem[idx]));
                d2 = clip32(longint'(va) - longint'(pos_mem[idx]));
                vel_sum = mul_q16(longint'(cfg_regs[CFG_INERTIA]), longint'(speed_mem[idx]))
                        + mul_q16(g1, d1) + mul_q16(g2, d2);
                speed_mem[idx] = DATA_W'(clip32(vel_sum));
                res.elem_value = speed_mem[idx];
            end
            OP_POS: begin
                next_pos = longint'(pos_mem[idx]) + longint'(speed_mem[idx]);
                // The upper bound is tested first, so it decides when the limits cross.
                if (next_pos > longint'(cfg_regs[CFG_UPPER])) begin
                    next_pos       = longint'(cfg_regs[CFG_UPPER]);
                    speed_mem[idx] = '0;
                end else if (next_pos < longint'(cfg_regs[CFG_LOWER])) begin
                    next_pos       = longint'(cfg_regs[CFG_LOWER]);
                    speed_mem[idx] = '0;
                end
                pos_mem[idx]   = DATA_W'(clip32(next_pos));
                res.elem_value = pos_mem[idx];
            end
            OP_PERTURB: begin
                speed_mem[idx] = DATA_W'(clip32(longint'(speed_mem[idx]) + longint'(va)));
                res.elem_value = speed_mem[idx];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_particle_result want;
        logic signed [DATA_W-1:0] got_value;
        logic [FIT_W-1:0]         got_fit;
        if (!i_rst_n) begin
            cfg_regs[CFG_INERTIA]    = '0;
            cfg_regs[CFG_OWN_GAIN]   = '0;
            cfg_regs[CFG_SWARM_GAIN] = '0;
            cfg_regs[CFG_LOWER]      = 32'sh8000_0000;
            cfg_regs[CFG_UPPER]      = 32'sh7FFF_FFFF;
            best_fit = '1;
            dot_acc  = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en && i_cfg_index <= CFG_UPPER) cfg_regs[i_cfg_index] = i_cfg_data;

            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(predict_particle_step(
                    i_s_tuser, i_s_tdata[2:0], i_s_tdata[34:3], i_s_tdata[66:35],
                    i_s_tdata[98:67], i_s_tdata[114:99], i_s_tdata[130:115], i_s_tlast));
            end

            if (i_m_tvalid && i_m_tready) begin
                got_value = i_m_tdata[31:0];
                got_fit   = i_m_tdata[62:32];
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result: tdata %h", i_m_tdata);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got_value !== want.elem_value) begin
                        $error("elem_value: expected %h, got %h", want.elem_value, got_value);
                        o_errors++;
                    end
                    if (got_fit !== want.fitness) begin
                        $error("fitness: expected %h, got %h", want.fitness, got_fit);
                        o_errors++;
                    end
                    if (i_m_tuser !== want.fitness_valid) begin
                        $error("fitness_valid: expected %b, got %b",
                               want.fitness_valid, i_m_tuser);
                        o_errors++;
                    end
                    if (i_m_tdata[63] !== want.improved) begin
                        $error("improved: expected %b, got %b", want.improved, i_m_tdata[63]);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/tb_pso_particle_update_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the particle update block: clock, reset, stimulus and verdict.
// Depends on psopu_pkg, pso_particle_update_top and pso_particle_update_check.
module tb_pso_particle_update_top
    import psopu_pkg::*;
();

    // The reserved operation codes are accepted by the block and answered with zeros.
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    // Q16.16 corner values used by the directed part and by the settings.
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int   fail_count;
    int   pending;
    int   items_sent = 0;
    int   stall_left = 0;
    // While set, neither side inserts idle cycles.
    logic no_gaps    = 1'b0;

    always #5 clk = ~clk;

    pso_particle_update_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pso_particle_update_check u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending)
    );

    // Receiver pacing. The ready line holds each level for a random stretch:
    // mostly ready, with short stalls and now and then a long one.
    always @(negedge clk) begin : rx_pacing
        int pick;
        if (no_gaps || !rst_n) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                m_tready   <= 1'b1;
                stall_left <= $urandom_range(0, 6);
            end else if (pick < 93) begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(8, 40);
            end
        end
    end

    // Operand values: the extremes and zero often, full-range values at times,
    // and small magnitudes most often so that sums stay inside the limits.
    function automatic logic [DATA_W-1:0] rand_q16();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3, 4, 5: return $urandom;
            default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
    endfunction

    // Random factor in [0, 1) as an unsigned Q0.16 value.
    function automatic logic [RAND_W-1:0] rand_fraction();
        return RAND_W'($urandom);
    endfunction

    // One input transfer. Called at a falling edge; returns at the falling edge
    // after the transfer. tvalid stays high when the next item follows at once,
    // so it is never dropped and raised in the same step.
    task automatic send_element(
        input logic [OP_W-1:0]   op,
        input logic [IDX_W-1:0]  idx,
        input logic [DATA_W-1:0] va,
        input logic [DATA_W-1:0] vb,
        input logic [DATA_W-1:0] tgt,
        input logic [RAND_W-1:0] r1,
        input logic [RAND_W-1:0] r2,
        input logic              last
    );
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 55) gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(5, 30);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({r2, r1, tgt, vb, va, idx});
        s_tuser  <= op;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result has been received.
    // Every item answers with exactly one result, so the block is idle then.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Write all five registers on consecutive cycles; the block must be idle.
    task automatic write_config(
        input logic [DATA_W-1:0] w,
        input logic [DATA_W-1:0] c1,
        input logic [DATA_W-1:0] c2,
        input logic [DATA_W-1:0] lo,
        input logic [DATA_W-1:0] hi
    );
        logic [DATA_W-1:0] vals [CFG_UPPER+1];
        vals[CFG_INERTIA]    = w;
        vals[CFG_OWN_GAIN]   = c1;
        vals[CFG_SWARM_GAIN] = c2;
        vals[CFG_LOWER]      = lo;
        vals[CFG_UPPER]      = hi;
        for (int i = CFG_INERTIA; i <= CFG_UPPER; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // One random sequence. Most are well-formed: full load passes, evaluate
    // passes that end with the last mark, and velocity/position steps. About a
    // tenth are noise with a random operation (reserved codes included) and a
    // random last mark, which may leave a partial dot product behind.
    task automatic run_random_sequence();
        int pick;
        int n;
        int idx;
        pick = $urandom_range(0, 99);
        idx  = $urandom_range(0, DIMENSIONS - 1);
        if (pick < 12) begin
            for (int k = 0; k < DIMENSIONS; k++)
                send_element(OP_LOAD, IDX_W'(k), rand_q16(), rand_q16(), $urandom,
                             rand_fraction(), rand_fraction(), 1'($urandom_range(0, 1)));
        end else if (pick < 35) begin
            n = $urandom_range(1, DIMENSIONS);
            for (int k = 0; k < n; k++)
                send_element(OP_EVAL, IDX_W'((idx + k) % DIMENSIONS), rand_q16(), $urandom,
                             rand_q16(), rand_fraction(), rand_fraction(), k == n - 1);
        end else if (pick < 60) begin
            send_element(OP_VEL, IDX_W'(idx), rand_q16(), $urandom, $urandom,
                         rand_fraction(), rand_fraction(), 1'($urandom_range(0, 1)));
            send_element(OP_POS, IDX_W'(idx), $urandom, $urandom, $urandom,
                         rand_fraction(), rand_fraction(), 1'($urandom_range(0, 1)));
        end else if (pick < 72) begin
            send_element(OP_PERTURB, IDX_W'(idx), rand_q16(), $urandom, $urandom,
                         rand_fraction(), rand_fraction(), 1'($urandom_range(0, 1)));
        end else if (pick < 82) begin
            send_element(OP_POS, IDX_W'(idx), $urandom, $urandom, $urandom,
                         rand_fraction(), rand_fraction(), 1'($urandom_range(0, 1)));
        end else if (pick < 90) begin
            send_element(OP_VEL, IDX_W'(idx), rand_q16(), $urandom, $urandom,
                         rand_fraction(), rand_fraction(), 1'($urandom_range(0, 1)));
        end else begin
            send_element(OP_W'($urandom_range(0, 7)), IDX_W'(idx), rand_q16(), rand_q16(),
                         rand_q16(), rand_fraction(), rand_fraction(),
                         1'($urandom_range(0, 1)));
        end
    endtask

    // A phase: drain the block, switch to new register values and then run
    // random sequences until the phase has sent its share of items.
    task automatic run_phase(
        input logic [DATA_W-1:0] w,
        input logic [DATA_W-1:0] c1,
        input logic [DATA_W-1:0] c2,
        input logic [DATA_W-1:0] lo,
        input logic [DATA_W-1:0] hi,
        input int                count,
        input logic              gapless
    );
        int stop_at;
        drain_outputs();
        no_gaps <= gapless;
        write_config(w, c1, c2, lo, hi);
        stop_at = items_sent + count;
        while (items_sent < stop_at) run_random_sequence();
    endtask

    initial begin : stimulus
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: w = 0.5, c1 = 1.5, c2 = 2.0, limits at -100.0 and 100.0.
        write_config(32'h0000_8000, 32'h0001_8000, 32'h0002_0000,
                     32'hFF9C_0000, 32'h0064_0000);

        // Load every element before anything reads it. Elements 0 to 5 sit at the
        // top of the range, element 6 at the bottom and element 7 at zero.
        send_element(OP_LOAD, 3'd0, Q_MAX, Q_MAX, '0, '0, '0, 1'b0);
        send_element(OP_LOAD, 3'd1, Q_MAX, Q_MIN, Q_MAX, 16'hFFFF, 16'hFFFF, 1'b1);
        send_element(OP_LOAD, 3'd2, Q_MAX, Q_ONE, '0, '0, '0, 1'b0);
        for (int k = 3; k < 6; k++)
            send_element(OP_LOAD, IDX_W'(k), Q_MAX, rand_q16(), $urandom, rand_fraction(),
                         rand_fraction(), 1'b0);
        send_element(OP_LOAD, 3'd6, Q_MIN, '0, Q_MIN, '0, '0, 1'b0);
        send_element(OP_LOAD, 3'd7, '0, '0, '0, '0, '0, 1'b0);

        // A full evaluate pass drives the dot product into positive saturation,
        // and the fitness saturates too. It still beats the freshly loaded best.
        for (int k = 0; k < DIMENSIONS; k++)
            send_element(OP_EVAL, IDX_W'(k), Q_MAX, $urandom, Q_MIN, rand_fraction(),
                         rand_fraction(), k == DIMENSIONS - 1);
        // Negative saturation; the fitness only ties the best, so no improvement.
        for (int k = 0; k < 3; k++)
            send_element(OP_EVAL, IDX_W'(k), Q_MIN, $urandom, Q_MAX, rand_fraction(),
                         rand_fraction(), k == 2);
        // A one-element pass with a small error improves and copies the position.
        send_element(OP_EVAL, 3'd7, Q_ONE, $urandom, 32'h0000_0003, rand_fraction(),
                     rand_fraction(), 1'b1);

        // Velocity with both random factors at their top and a swarm best far
        // below: the difference and the sum saturate.
        send_element(OP_VEL, 3'd0, Q_MIN, $urandom, $urandom, 16'hFFFF, 16'hFFFF, 1'b0);
        // Position past the upper limit is clamped and the speed cleared.
        send_element(OP_POS, 3'd2, $urandom, $urandom, $urandom, rand_fraction(),
                     rand_fraction(), 1'b0);
        // Drive element 6 below the lower limit, then saturate its speed upward.
        send_element(OP_PERTURB, 3'd6, Q_MIN, $urandom, $urandom, rand_fraction(),
                     rand_fraction(), 1'b0);
        send_element(OP_POS, 3'd6, $urandom, $urandom, $urandom, rand_fraction(),
                     rand_fraction(), 1'b1);
        send_element(OP_PERTURB, 3'd6, Q_MAX, $urandom, $urandom, rand_fraction(),
                     rand_fraction(), 1'b0);
        send_element(OP_PERTURB, 3'd6, Q_MAX, $urandom, $urandom, rand_fraction(),
                     rand_fraction(), 1'b0);
        // Reserved operations change nothing.
        send_element(OP_RSVD5, 3'd1, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF, 16'hFFFF, 1'b1);
        send_element(OP_RSVD6, 3'd2, $urandom, $urandom, $urandom, rand_fraction(),
                     rand_fraction(), 1'b0);
        send_element(OP_RSVD7, 3'd7, Q_MIN, Q_MIN, Q_MIN, '0, '0, 1'b1);

        // Random phases over several register settings. Each phase starts by
        // pausing until the block has answered everything.
        run_phase('0, '0, '0, Q_MIN, Q_MAX, 90, 1'b0);
        // Crossed limits: the upper test decides.
        run_phase(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 90, 1'b0);
        run_phase(Q_MIN, Q_MIN, Q_MAX, 32'hFFFB_0000, 32'h0005_0000, 90, 1'b1);
        run_phase(32'h0000_B333, 32'h0001_8000, 32'h0001_8000,
                  32'hFFCE_0000, 32'h0032_0000, 130, 1'b0);
        run_phase(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(), 100, 1'b0);

        drain_outputs();
        // Give a stray extra result time to show up.
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("[pso_particle_update_top] OK");
        end else begin
            $display("[pso_particle_update_top] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of a few hundred thousand ns.
    initial begin : watchdog
        #5_000_000;
        $display("[pso_particle_update_top] ERROR");
        $finish;
    end

endmodule
